[hw/rtl/pit_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_pkg
// Shared types and codes for the polygon intersection test block.
// ----------------------------------------------------------------------------
package pit_pkg;

	// kind of evaluation a finished pair needs
	typedef enum logic [2:0] {
		MD_STATUS = 3'd0,   // no geometry work, status only
		MD_PP     = 3'd1,   // point with point
		MD_PA_RB  = 3'd2,   // point A inside ring B
		MD_PB_RA  = 3'd3,   // point B inside ring A
		MD_RR     = 3'd4    // ring with ring
	} mode_t;

	localparam logic [1:0] ST_EVALUATED   = 2'd0;
	localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
	localparam logic [1:0] ST_EMPTY       = 2'd2;
	localparam logic [1:0] ST_OVERFLOW    = 2'd3;

	localparam logic [1:0] KIND_POINT = 2'd0;
	localparam logic [1:0] KIND_RING  = 2'd1;

	localparam logic OP_FIRST  = 1'b0;
	localparam logic OP_SECOND = 1'b1;

	// vertex store write control
	typedef struct packed {
		logic en;
		logic sel;
	} wr_ctl_t;

	localparam int MODE_W = 3;

endpackage

[hw/rtl/pit_jobq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_jobq
// Two-entry job queue between the loader and the evaluator.
// ----------------------------------------------------------------------------
module pit_jobq import pit_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] push_data,
	output logic         push_ready,
	input  logic         pop,
	output logic         pop_valid,
	output logic [W-1:0] pop_data
);

	logic [W-1:0] entry_q [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   cnt_q;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = entry_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push && push_ready) begin
			entry_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push && push_ready) wptr_q <= ~wptr_q;
			if (pop && pop_valid) rptr_q <= ~rptr_q;
			case ({push && push_ready, pop && pop_valid})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[hw/rtl/pit_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_front
// Vertex loader: counts, kinds, overflow, and job classification.
// ----------------------------------------------------------------------------
module pit_front import pit_pkg::*; #(
	parameter int MAX_VERTS   = 256,
	parameter int COORD_WIDTH = 32,
	localparam int AW   = $clog2(MAX_VERTS),
	localparam int CNTW = $clog2(MAX_VERTS + 1),
	localparam int JW   = MODE_W + 2 + 2 * CNTW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          opcode,
	input  logic [1:0]                    kind,
	input  logic signed [COORD_WIDTH-1:0] x_coord,
	input  logic signed [COORD_WIDTH-1:0] y_coord,
	input  logic                          last_of_pair,
	output wr_ctl_t                       wr,
	output logic [AW-1:0]                 waddr,
	output logic [2*COORD_WIDTH-1:0]      wdata,
	output logic                          job_push,
	output logic [JW-1:0]                 job_data,
	input  logic                          job_ready,
	input  logic                          release_job
);

	logic [CNTW-1:0] cnt_a_q, cnt_b_q;
	logic [1:0]      kind_a_q, kind_b_q;
	logic            ovf_q;
	logic            pending_q;

	logic            accept;
	logic [CNTW-1:0] sel_cnt, na_n, nb_n;
	logic [1:0]      ka_n, kb_n, st;
	logic            full, ovf_n;
	mode_t           mode;

	assign in_ready = !pending_q && job_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		sel_cnt = (opcode == OP_SECOND) ? cnt_b_q : cnt_a_q;
		full    = (sel_cnt == CNTW'(MAX_VERTS));
		na_n    = (opcode == OP_FIRST && !full) ? cnt_a_q + CNTW'(1) : cnt_a_q;
		nb_n    = (opcode == OP_SECOND && !full) ? cnt_b_q + CNTW'(1) : cnt_b_q;
		ka_n    = (opcode == OP_FIRST) ? kind : kind_a_q;
		kb_n    = (opcode == OP_SECOND) ? kind : kind_b_q;
		ovf_n   = ovf_q | full;
		st      = ST_EVALUATED;
		mode    = MD_STATUS;
		if (ovf_n) begin
			st = ST_OVERFLOW;
		end else if (ka_n[1] || kb_n[1]) begin
			st = ST_UNSUPPORTED;
		end else if (na_n == '0 || nb_n == '0) begin
			st = ST_EMPTY;
		end else if (ka_n == KIND_POINT && kb_n == KIND_POINT) begin
			mode = MD_PP;
		end else if (ka_n == KIND_POINT) begin
			mode = MD_PA_RB;
		end else if (kb_n == KIND_POINT) begin
			mode = MD_PB_RA;
		end else begin
			mode = MD_RR;
		end
	end

	assign wr.en    = accept && !full;
	assign wr.sel   = opcode;
	assign waddr    = sel_cnt[AW-1:0];
	assign wdata    = {y_coord, x_coord};
	assign job_push = accept && last_of_pair;
	assign job_data = {mode, st, na_n, nb_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_a_q   <= '0;
			cnt_b_q   <= '0;
			kind_a_q  <= KIND_POINT;
			kind_b_q  <= KIND_POINT;
			ovf_q     <= 1'b0;
			pending_q <= 1'b0;
		end else begin
			if (release_job) pending_q <= 1'b0;
			if (accept) begin
				if (last_of_pair) begin
					cnt_a_q   <= '0;
					cnt_b_q   <= '0;
					kind_a_q  <= KIND_POINT;
					kind_b_q  <= KIND_POINT;
					ovf_q     <= 1'b0;
					pending_q <= 1'b1;
				end else begin
					cnt_a_q  <= na_n;
					cnt_b_q  <= nb_n;
					kind_a_q <= ka_n;
					kind_b_q <= kb_n;
					ovf_q    <= ovf_n;
				end
			end
		end
	end

endmodule

[hw/rtl/pit_cross.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_cross
// Sign of (a-o) x (b-o), from one shared multiplier.
// ----------------------------------------------------------------------------
module pit_cross import pit_pkg::*; #(
	parameter int COORD_WIDTH = 32,
	localparam int DW = COORD_WIDTH + 1,
	localparam int PW = 2 * DW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic signed [COORD_WIDTH-1:0] ox,
	input  logic signed [COORD_WIDTH-1:0] oy,
	input  logic signed [COORD_WIDTH-1:0] ax,
	input  logic signed [COORD_WIDTH-1:0] ay,
	input  logic signed [COORD_WIDTH-1:0] bx,
	input  logic signed [COORD_WIDTH-1:0] by,
	output logic                          done,
	output logic                          neg,
	output logic                          zero
);

	logic signed [DW-1:0] dx1_q, dy2_q, dy1_q, dx2_q;
	logic signed [PW-1:0] p1_q, p2_q;
	logic signed [PW:0]   diff;
	logic signed [DW-1:0] m_a, m_b;
	logic [1:0]           ph_q;

	// phase 1 multiplies dx1*dy2, phase 2 dy1*dx2
	assign m_a  = (ph_q == 2'd1) ? dx1_q : dy1_q;
	assign m_b  = (ph_q == 2'd1) ? dy2_q : dx2_q;
	assign diff = (PW+1)'(p1_q) - (PW+1)'(p2_q);
	assign done = (ph_q == 2'd3);
	assign neg  = diff[PW];
	assign zero = (diff == '0);

	always_ff @(posedge clk) begin
		if (start) begin
			dx1_q <= DW'(ax) - DW'(ox);
			dy2_q <= DW'(by) - DW'(oy);
			dy1_q <= DW'(ay) - DW'(oy);
			dx2_q <= DW'(bx) - DW'(ox);
		end
		if (ph_q == 2'd1) p1_q <= m_a * m_b;
		if (ph_q == 2'd2) p2_q <= m_a * m_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= 2'd0;
		end else begin
			case (ph_q)
				2'd0:    ph_q <= start ? 2'd1 : 2'd0;
				2'd1:    ph_q <= 2'd2;
				2'd2:    ph_q <= 2'd3;
				default: ph_q <= 2'd0;
			endcase
		end
	end

endmodule

[hw/rtl/pit_eval.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pit_eval
// Evaluator: vertex stores, edge walk sequencer and result register.
// ----------------------------------------------------------------------------
module pit_eval import pit_pkg::*; #(
	parameter int MAX_VERTS   = 256,
	parameter int COORD_WIDTH = 32,
	localparam int AW   = $clog2(MAX_VERTS),
	localparam int CNTW = $clog2(MAX_VERTS + 1),
	localparam int JW   = MODE_W + 2 + 2 * CNTW,
	localparam int CW   = COORD_WIDTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  wr_ctl_t          wr,
	input  logic [AW-1:0]    waddr,
	input  logic [2*CW-1:0]  wdata,
	input  logic             job_valid,
	input  logic [JW-1:0]    job_data,
	output logic             job_pop,
	output logic             release_job,
	output logic             out_valid,
	input  logic             out_ready,
	output logic             intersects,
	output logic [1:0]       status
);

	typedef enum logic [16:0] {
		S_IDLE     = 17'h00001,
		S_PP       = 17'h00002,
		S_LDP      = 17'h00004,
		S_IN_START = 17'h00008,
		S_IN_LAST  = 17'h00010,
		S_IN_LD    = 17'h00020,
		S_IN_TEST  = 17'h00040,
		S_IN_WAIT  = 17'h00080,
		S_IN_NEXT  = 17'h00100,
		S_IN_END   = 17'h00200,
		S_RR_PRE   = 17'h00400,
		S_RR_OUT   = 17'h00800,
		S_RR_IN    = 17'h01000,
		S_RR_X     = 17'h02000,
		S_RR_XW    = 17'h04000,
		S_RR_DEC   = 17'h08000,
		S_DONE     = 17'h10000
	} state_t;

	logic [2*CW-1:0] mem_a [MAX_VERTS];
	logic [2*CW-1:0] mem_b [MAX_VERTS];
	logic [2*CW-1:0] a_rd_q, b_rd_q, r_rd, p_rd;
	logic [AW-1:0]   a_raddr, b_raddr;

	state_t          state_q;
	mode_t           mode_q, j_mode;
	logic [1:0]      st_q, j_st;
	logic [CNTW-1:0] na_q, nb_q, j_na, j_nb, rn;
	logic            ring_q, phase_q, in_q, hit_q;
	logic [AW-1:0]   idx_q, i_q, k_q;
	logic [1:0]      s_idx_q;
	logic [3:0]      sneg_q, szero_q;
	logic            out_valid_q, intersects_q;
	logic [1:0]      status_q;

	logic signed [CW-1:0] ap_x, ap_y, ac_x, ac_y, bp_x, bp_y, bc_x, bc_y, pt_x, pt_y;
	logic signed [CW-1:0] c_ox, c_oy, c_ax, c_ay, c_bx, c_by;
	logic                 c_start, c_done, c_neg, c_zero;

	logic in_cond, in_hit, k_last, i_last, n_last, meet, cross_pair;

	assign j_mode = mode_t'(job_data[JW-1 -: MODE_W]);
	assign {j_st, j_na, j_nb} = job_data[JW-MODE_W-1:0];

	// ring under test and the point's source store
	assign r_rd = (ring_q == OP_FIRST) ? a_rd_q : b_rd_q;
	assign p_rd = (ring_q == OP_FIRST) ? b_rd_q : a_rd_q;
	assign rn   = (ring_q == OP_FIRST) ? na_q : nb_q;

	always_ff @(posedge clk) begin
		if (wr.en && wr.sel == OP_FIRST) mem_a[waddr] <= wdata;
		if (wr.en && wr.sel == OP_SECOND) mem_b[waddr] <= wdata;
		a_rd_q <= mem_a[a_raddr];
		b_rd_q <= mem_b[b_raddr];
	end

	function automatic logic btw(input logic signed [CW-1:0] a, input logic signed [CW-1:0] b,
		input logic signed [CW-1:0] d);
		btw = (a <= d && d <= b) || (b <= d && d <= a);
	endfunction

	always_comb begin
		in_cond    = (pt_y < ac_y) != (pt_y < ap_y);
		in_hit     = (ac_y < ap_y) ? c_neg : (!c_neg && !c_zero);
		k_last     = (CNTW'(k_q) == nb_q - CNTW'(1));
		i_last     = (CNTW'(i_q) == na_q - CNTW'(1));
		n_last     = (CNTW'(idx_q) == rn - CNTW'(1));
		cross_pair = !szero_q[0] && !szero_q[1] && (sneg_q[0] != sneg_q[1]) &&
		             !szero_q[2] && !szero_q[3] && (sneg_q[2] != sneg_q[3]);
		meet = cross_pair ||
		       (szero_q[0] && btw(bp_x, bc_x, ap_x) && btw(bp_y, bc_y, ap_y)) ||
		       (szero_q[1] && btw(bp_x, bc_x, ac_x) && btw(bp_y, bc_y, ac_y)) ||
		       (szero_q[2] && btw(ap_x, ac_x, bp_x) && btw(ap_y, ac_y, bp_y)) ||
		       (szero_q[3] && btw(ap_x, ac_x, bc_x) && btw(ap_y, ac_y, bc_y));
	end

	// read addresses and cross unit operands
	always_comb begin
		a_raddr = '0;
		b_raddr = '0;
		c_start = 1'b0;
		c_ox = ac_x; c_oy = ac_y; c_ax = pt_x; c_ay = pt_y; c_bx = ap_x; c_by = ap_y;
		job_pop = 1'b0;
		case (state_q)
			S_IDLE: begin
				job_pop = job_valid;
				if (j_mode == MD_RR) a_raddr = AW'(j_na - CNTW'(1));
			end
			S_IN_START: begin
				a_raddr = AW'(na_q - CNTW'(1));
				b_raddr = AW'(nb_q - CNTW'(1));
			end
			S_IN_NEXT: begin
				a_raddr = idx_q + AW'(1);
				b_raddr = idx_q + AW'(1);
			end
			S_IN_TEST: c_start = in_cond;
			S_RR_PRE: b_raddr = AW'(nb_q - CNTW'(1));
			S_RR_DEC: begin
				if (!k_last) begin
					b_raddr = k_q + AW'(1);
				end else if (!i_last) begin
					a_raddr = i_q + AW'(1);
					b_raddr = AW'(nb_q - CNTW'(1));
				end
			end
			S_RR_X: c_start = 1'b1;
			default: ;
		endcase
		if (state_q == S_RR_X || state_q == S_RR_XW) begin
			case (s_idx_q)
				2'd0: begin
					c_ox = bp_x; c_oy = bp_y; c_ax = bc_x; c_ay = bc_y; c_bx = ap_x; c_by = ap_y;
				end
				2'd1: begin
					c_ox = bp_x; c_oy = bp_y; c_ax = bc_x; c_ay = bc_y; c_bx = ac_x; c_by = ac_y;
				end
				2'd2: begin
					c_ox = ap_x; c_oy = ap_y; c_ax = ac_x; c_ay = ac_y; c_bx = bp_x; c_by = bp_y;
				end
				default: begin
					c_ox = ap_x; c_oy = ap_y; c_ax = ac_x; c_ay = ac_y; c_bx = bc_x; c_by = bc_y;
				end
			endcase
		end
	end

	pit_cross #(.COORD_WIDTH(CW)) u_cross (
		.clk   (clk),
		.arst_n(arst_n),
		.start (c_start),
		.ox    (c_ox),
		.oy    (c_oy),
		.ax    (c_ax),
		.ay    (c_ay),
		.bx    (c_bx),
		.by    (c_by),
		.done  (c_done),
		.neg   (c_neg),
		.zero  (c_zero)
	);

	// vertex and point registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_LDP: begin
				pt_x <= p_rd[CW-1:0];
				pt_y <= p_rd[2*CW-1:CW];
			end
			S_IN_LAST, S_RR_PRE: begin
				ac_x <= (state_q == S_RR_PRE) ? a_rd_q[CW-1:0] : r_rd[CW-1:0];
				ac_y <= (state_q == S_RR_PRE) ? a_rd_q[2*CW-1:CW] : r_rd[2*CW-1:CW];
			end
			S_IN_LD: begin
				ap_x <= ac_x;
				ap_y <= ac_y;
				ac_x <= r_rd[CW-1:0];
				ac_y <= r_rd[2*CW-1:CW];
			end
			S_RR_OUT: begin
				ap_x <= ac_x;
				ap_y <= ac_y;
				ac_x <= a_rd_q[CW-1:0];
				ac_y <= a_rd_q[2*CW-1:CW];
				bc_x <= b_rd_q[CW-1:0];
				bc_y <= b_rd_q[2*CW-1:CW];
			end
			S_RR_IN: begin
				bp_x <= bc_x;
				bp_y <= bc_y;
				bc_x <= b_rd_q[CW-1:0];
				bc_y <= b_rd_q[2*CW-1:CW];
			end
			S_RR_XW: begin
				if (c_done) begin
					sneg_q[s_idx_q]  <= c_neg;
					szero_q[s_idx_q] <= c_zero;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= MD_STATUS;
			st_q         <= ST_EVALUATED;
			na_q         <= '0;
			nb_q         <= '0;
			ring_q       <= OP_FIRST;
			phase_q      <= 1'b0;
			in_q         <= 1'b0;
			hit_q        <= 1'b0;
			idx_q        <= '0;
			i_q          <= '0;
			k_q          <= '0;
			s_idx_q      <= 2'd0;
			out_valid_q  <= 1'b0;
			intersects_q <= 1'b0;
			status_q     <= ST_EVALUATED;
		end else begin
			if (release_job) out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (job_valid) begin
						mode_q  <= j_mode;
						st_q    <= j_st;
						na_q    <= j_na;
						nb_q    <= j_nb;
						hit_q   <= 1'b0;
						phase_q <= 1'b0;
						i_q     <= '0;
						case (j_mode)
							MD_PP:    state_q <= S_PP;
							MD_PA_RB: begin
								ring_q  <= OP_SECOND;
								state_q <= S_LDP;
							end
							MD_PB_RA: begin
								ring_q  <= OP_FIRST;
								state_q <= S_LDP;
							end
							MD_RR:    state_q <= S_RR_PRE;
							default:  state_q <= S_DONE;
						endcase
					end
				end
				S_PP: begin
					hit_q   <= (a_rd_q == b_rd_q);
					state_q <= S_DONE;
				end
				S_LDP: state_q <= S_IN_START;
				S_IN_START: begin
					in_q  <= 1'b0;
					idx_q <= '0;
					state_q <= (rn < CNTW'(3)) ? S_IN_END : S_IN_LAST;
				end
				S_IN_LAST: state_q <= S_IN_LD;
				S_IN_LD:   state_q <= S_IN_TEST;
				S_IN_TEST: state_q <= in_cond ? S_IN_WAIT : S_IN_NEXT;
				S_IN_WAIT: begin
					if (c_done) begin
						in_q    <= in_q ^ in_hit;
						state_q <= S_IN_NEXT;
					end
				end
				S_IN_NEXT: begin
					idx_q   <= idx_q + AW'(1);
					state_q <= n_last ? S_IN_END : S_IN_LD;
				end
				S_IN_END: begin
					if (mode_q == MD_RR && !phase_q && !in_q) begin
						// ring A's first vertex missed ring B: try B's first vertex in A
						phase_q <= 1'b1;
						ring_q  <= OP_FIRST;
						state_q <= S_LDP;
					end else begin
						hit_q   <= in_q;
						state_q <= S_DONE;
					end
				end
				S_RR_PRE: state_q <= S_RR_OUT;
				S_RR_OUT: begin
					k_q     <= '0;
					state_q <= S_RR_IN;
				end
				S_RR_IN: begin
					s_idx_q <= 2'd0;
					state_q <= S_RR_X;
				end
				S_RR_X: state_q <= S_RR_XW;
				S_RR_XW: begin
					if (c_done) begin
						s_idx_q <= s_idx_q + 2'd1;
						state_q <= (s_idx_q == 2'd3) ? S_RR_DEC : S_RR_X;
					end
				end
				S_RR_DEC: begin
					if (meet) begin
						hit_q   <= 1'b1;
						state_q <= S_DONE;
					end else if (!k_last) begin
						k_q     <= k_q + AW'(1);
						state_q <= S_RR_IN;
					end else if (!i_last) begin
						i_q     <= i_q + AW'(1);
						state_q <= S_RR_OUT;
					end else begin
						ring_q  <= OP_SECOND;
						state_q <= S_LDP;
					end
				end
				S_DONE: begin
					if (!out_valid_q || out_ready) begin
						intersects_q <= hit_q && (st_q == ST_EVALUATED);
						status_q     <= st_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign release_job = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign out_valid   = out_valid_q;
	assign intersects  = intersects_q;
	assign status      = status_q;

`ifndef SYNTH
	a_cross_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		c_done |-> (state_q == S_IN_WAIT || state_q == S_RR_XW))
		else $error("cross result arrived outside a wait state");
	a_no_hit_on_error: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_EVALUATED) |-> !intersects_q)
		else $error("intersect flag set on a non-evaluated result");
	a_pop_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> state_q == S_IDLE)
		else $error("job popped while busy");
	a_release_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		release_job |=> out_valid_q)
		else $error("release without a result");
`endif

endmodule

[hw/rtl/polygon_intersection_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_intersection_test
// Loads two geometries vertex by vertex and reports whether they touch.
// ----------------------------------------------------------------------------
// Edge signs are computed one at a time on the shared cross-product multiplier.
// Throughput: one vertex per cycle; input stalls while a pair is evaluated.
// Reset: arst_n clears counts, kinds, overflow flag, queue and sequencer;
//   vertex stores are not cleared and are only read below the fill count.
module polygon_intersection_test import pit_pkg::*; #(
	parameter int MAX_VERTS   = 256,
	parameter int COORD_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          opcode,
	input  logic [1:0]                    kind,
	input  logic signed [COORD_WIDTH-1:0] x_coord,
	input  logic signed [COORD_WIDTH-1:0] y_coord,
	input  logic                          last_of_pair,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          intersects,
	output logic [1:0]                    status
);

	localparam int AW   = $clog2(MAX_VERTS);
	localparam int CNTW = $clog2(MAX_VERTS + 1);
	localparam int JW   = MODE_W + 2 + 2 * CNTW;

	wr_ctl_t                  wr;
	logic [AW-1:0]            waddr;
	logic [2*COORD_WIDTH-1:0] wdata;
	logic                     job_push, job_ready, job_valid, job_pop, release_job;
	logic [JW-1:0]            job_in, job_out;

	// front: stores vertices, classifies the pair on the closing transaction
	pit_front #(.MAX_VERTS(MAX_VERTS), .COORD_WIDTH(COORD_WIDTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.kind        (kind),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.last_of_pair(last_of_pair),
		.wr          (wr),
		.waddr       (waddr),
		.wdata       (wdata),
		.job_push    (job_push),
		.job_data    (job_in),
		.job_ready   (job_ready),
		.release_job (release_job)
	);

	// job queue decouples classification from evaluation
	pit_jobq #(.W(JW)) u_jobq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (job_push),
		.push_data (job_in),
		.push_ready(job_ready),
		.pop       (job_pop),
		.pop_valid (job_valid),
		.pop_data  (job_out)
	);

	// back: edge walk, containment, result register
	pit_eval #(.MAX_VERTS(MAX_VERTS), .COORD_WIDTH(COORD_WIDTH)) u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (wr),
		.waddr      (waddr),
		.wdata      (wdata),
		.job_valid  (job_valid),
		.job_data   (job_out),
		.job_pop    (job_pop),
		.release_job(release_job),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.intersects (intersects),
		.status     (status)
	);

endmodule

[test/polygon_intersection_test_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_intersection_test_tb
// Self-checking bench: streams vertex transactions for geometry pairs,
// predicts each pair's intersect bit and status, and compares results in order.
// ----------------------------------------------------------------------------
module polygon_intersection_test_tb;
	import pit_pkg::*;

	localparam int MAX_VERTS   = 256;
	localparam int COORD_WIDTH = 32;
	localparam int TARGET_ITEMS = 750;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	// one vertex transaction, with an optional hand-written expectation
	typedef struct packed {
		logic       op;
		logic [1:0] kind;
		coord_t     x;
		coord_t     y;
		logic       last;
		logic       fixed;
		logic       f_hit;
		logic [1:0] f_st;
	} vertex_t;

	typedef struct packed {
		logic       hit;
		logic [1:0] st;
	} verdict_t;

	localparam coord_t CMAX = 32'sh7fffffff;
	localparam coord_t CMIN = 32'sh80000000;

	// directed table; rows with fixed set carry their expected verdict
	localparam int DIR_N = 22;
	localparam vertex_t DIR_TAB [DIR_N] = '{
		// equal points at the origin
		'{OP_FIRST,  KIND_POINT, 0, 0, 0, 0, 0, 0},
		'{OP_SECOND, KIND_POINT, 0, 0, 1, 1, 1, ST_EVALUATED},
		// points at opposite extremes
		'{OP_FIRST,  KIND_POINT, CMAX, CMAX, 0, 0, 0, 0},
		'{OP_SECOND, KIND_POINT, CMIN, CMIN, 1, 1, 0, ST_EVALUATED},
		// unsupported kind on A
		'{OP_FIRST,  2'd2,       5, 5, 0, 0, 0, 0},
		'{OP_SECOND, KIND_POINT, 5, 5, 1, 1, 0, ST_UNSUPPORTED},
		// kind three on B with A empty: unsupported wins over empty
		'{OP_SECOND, 2'd3,       1, 1, 1, 1, 0, ST_UNSUPPORTED},
		// trigger on opcode 0 with B empty
		'{OP_FIRST,  KIND_POINT, 7, 7, 1, 1, 0, ST_EMPTY},
		// point A inside square ring B
		'{OP_SECOND, KIND_RING,  0, 0, 0, 0, 0, 0},
		'{OP_SECOND, KIND_RING,  10, 0, 0, 0, 0, 0},
		'{OP_SECOND, KIND_RING,  10, 10, 0, 0, 0, 0},
		'{OP_FIRST,  KIND_POINT, 5, 5, 0, 0, 0, 0},
		'{OP_SECOND, KIND_RING,  0, 10, 1, 0, 0, 0},
		// two crossing triangles, extreme-sized
		'{OP_FIRST,  KIND_RING,  CMIN, CMIN, 0, 0, 0, 0},
		'{OP_FIRST,  KIND_RING,  CMAX, CMIN, 0, 0, 0, 0},
		'{OP_FIRST,  KIND_RING,  0, CMAX, 0, 0, 0, 0},
		'{OP_SECOND, KIND_RING,  CMIN, CMAX, 0, 0, 0, 0},
		'{OP_SECOND, KIND_RING,  CMAX, CMAX, 0, 0, 0, 0},
		'{OP_SECOND, KIND_RING,  0, CMIN, 1, 0, 0, 0},
		// two-vertex ring against point
		'{OP_FIRST,  KIND_RING,  0, 0, 0, 0, 0, 0},
		'{OP_FIRST,  KIND_RING,  4, 4, 0, 0, 0, 0},
		'{OP_SECOND, KIND_POINT, 2, 2, 1, 0, 0, 0}
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic       opcode = 1'b0;
	logic [1:0] kind = 2'd0;
	coord_t     x_coord = '0;
	coord_t     y_coord = '0;
	logic       last_of_pair = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       intersects;
	logic [1:0] status;

	// bench-side tags travelling with the current transaction
	logic       cur_fixed = 1'b0;
	verdict_t   cur_fixed_v = '0;

	vertex_t  stim_q[$];
	verdict_t verdict_q[$];
	int       errors = 0;
	int       sent = 0;
	int       results_seen = 0;

	// predictor state: index 0 is geometry A, 1 is geometry B
	coord_t     gx [2][MAX_VERTS];
	coord_t     gy [2][MAX_VERTS];
	int         gcount [2];
	logic [1:0] gkind [2];
	bit         overflowed;

	polygon_intersection_test #(
		.MAX_VERTS  (MAX_VERTS),
		.COORD_WIDTH(COORD_WIDTH)
	) i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.kind        (kind),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.last_of_pair(last_of_pair),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.intersects  (intersects),
		.status      (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- geometry
	// sign of (a-o) x (b-o), exact at 128 bits
	function automatic int cross_sign(longint ox, longint oy, longint ax, longint ay,
			longint bx, longint by);
		logic signed [127:0] p, q, d;
		p = 128'(ax - ox);
		p = p * 128'(by - oy);
		q = 128'(ay - oy);
		q = q * 128'(bx - ox);
		d = p - q;
		return (d < 0) ? -1 : ((d == 0) ? 0 : 1);
	endfunction

	function automatic bit in_span(longint a, longint b, longint d);
		if (b < a) return (d >= b) && (d <= a);
		return (d >= a) && (d <= b);
	endfunction

	// p lies on segment q-r
	function automatic bit on_segment(longint px, longint py, longint qx, longint qy,
			longint rx, longint ry);
		return cross_sign(qx, qy, rx, ry, px, py) == 0 &&
			in_span(qx, rx, px) && in_span(qy, ry, py);
	endfunction

	function automatic bit segments_meet(longint ax, longint ay, longint bx, longint by,
			longint cx, longint cy, longint dx, longint dy);
		int s1, s2, s3, s4;
		s1 = cross_sign(cx, cy, dx, dy, ax, ay);
		s2 = cross_sign(cx, cy, dx, dy, bx, by);
		s3 = cross_sign(ax, ay, bx, by, cx, cy);
		s4 = cross_sign(ax, ay, bx, by, dx, dy);
		if (s1 * s2 < 0 && s3 * s4 < 0) return 1;
		return on_segment(ax, ay, cx, cy, dx, dy) || on_segment(bx, by, cx, cy, dx, dy) ||
			on_segment(cx, cy, ax, ay, bx, by) || on_segment(dx, dy, ax, ay, bx, by);
	endfunction

	// even-odd ray cast, division replaced by a cross-multiplied compare
	function automatic bit point_in_ring(longint px, longint py, int g);
		int n, j;
		bit in;
		longint xi, yi, xj, yj, den;
		logic signed [127:0] l, r;
		n = gcount[g];
		in = 0;
		if (n < 3) return 0;
		j = n - 1;
		for (int i = 0; i < n; i++) begin
			xi = gx[g][i]; yi = gy[g][i]; xj = gx[g][j]; yj = gy[g][j];
			if ((py < yi) != (py < yj)) begin
				den = yj - yi;
				l = 128'(px - xi);
				l = l * 128'(den);
				r = 128'(xj - xi);
				r = r * 128'(py - yi);
				if (den > 0 ? (l < r) : (l > r)) in = !in;
			end
			j = i;
		end
		return in;
	endfunction

	function automatic bit rings_meet();
		int j, l;
		j = gcount[0] - 1;
		for (int i = 0; i < gcount[0]; i++) begin
			l = gcount[1] - 1;
			for (int k = 0; k < gcount[1]; k++) begin
				if (segments_meet(gx[0][j], gy[0][j], gx[0][i], gy[0][i],
						gx[1][l], gy[1][l], gx[1][k], gy[1][k]))
					return 1;
				l = k;
			end
			j = i;
		end
		if (point_in_ring(gx[0][0], gy[0][0], 1)) return 1;
		return point_in_ring(gx[1][0], gy[1][0], 0);
	endfunction

	// verdict of the pair now held in the stores
	function automatic verdict_t judge_pair();
		verdict_t v;
		v = '0;
		if (overflowed) v.st = ST_OVERFLOW;
		else if (gkind[0] > KIND_RING || gkind[1] > KIND_RING) v.st = ST_UNSUPPORTED;
		else if (gcount[0] == 0 || gcount[1] == 0) v.st = ST_EMPTY;
		else begin
			v.st = ST_EVALUATED;
			if (gkind[0] == KIND_POINT && gkind[1] == KIND_POINT)
				v.hit = (gx[0][0] == gx[1][0]) && (gy[0][0] == gy[1][0]);
			else if (gkind[0] == KIND_POINT)
				v.hit = point_in_ring(gx[0][0], gy[0][0], 1);
			else if (gkind[1] == KIND_POINT)
				v.hit = point_in_ring(gx[1][0], gy[1][0], 0);
			else
				v.hit = rings_meet();
		end
		return v;
	endfunction

	task automatic report(string what, int want, int got);
		$display("mismatch: %s expected %0d got %0d", what, want, got);
		errors++;
	endtask

	// ---------------------------------------------------------------- monitors
	// accepted vertex: update predictor; a closing vertex queues a verdict
	always @(posedge clk) begin
		int g;
		verdict_t v;
		if (arst_n && in_valid && in_ready) begin
			g = (opcode == OP_SECOND) ? 1 : 0;
			gkind[g] = kind;
			if (gcount[g] < MAX_VERTS) begin
				gx[g][gcount[g]] = x_coord;
				gy[g][gcount[g]] = y_coord;
				gcount[g]++;
			end else
				overflowed = 1;
			if (last_of_pair) begin
				v = judge_pair();
				verdict_q = {verdict_q, (cur_fixed ? cur_fixed_v : v)};
				gcount[0] = 0; gcount[1] = 0;
				gkind[0] = KIND_POINT; gkind[1] = KIND_POINT;
				overflowed = 0;
			end
		end
	end

	// accepted result: compare against the oldest pending verdict
	always @(posedge clk) begin
		verdict_t v;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (verdict_q.size() == 0)
				report("unexpected result, status", -1, status);
			else begin
				v = verdict_q.pop_front();
				if (intersects !== v.hit) report("intersects", v.hit, intersects);
				if (status !== v.st) report("status", v.st, status);
			end
		end
	end

	// ---------------------------------------------------------------- stimulus
	function automatic coord_t pick_coord(int mode);
		case (mode)
			0: return coord_t'($urandom_range(32)) - 16;
			1: return coord_t'($urandom);
			default: return ($urandom_range(1)) ? CMAX : CMIN;
		endcase
	endfunction

	function automatic logic [1:0] pick_kind();
		int r;
		r = $urandom_range(99);
		if (r < 45) return KIND_RING;
		if (r < 88) return KIND_POINT;
		return logic'($urandom_range(1)) ? 2'd3 : 2'd2;
	endfunction

	// one geometry pair with random sizes and a random A/B interleave
	task automatic add_pair(int big);
		logic [1:0] ka, kb;
		int na, nb, mode, ia, ib;
		vertex_t v;
		ka = pick_kind();
		kb = pick_kind();
		na = (ka == KIND_RING) ? $urandom_range(7, 1) : $urandom_range(2, 1);
		nb = (kb == KIND_RING) ? $urandom_range(7, 1) : $urandom_range(2, 1);
		if ($urandom_range(19) == 0) na = 0;           // empty geometry A
		if (big) begin ka = KIND_RING; na = MAX_VERTS; kb = KIND_RING; nb = 3; end
		mode = $urandom_range(9);
		mode = (mode < 6) ? 0 : ((mode < 9) ? 1 : 2);
		ia = 0; ib = 0;
		while (ia + ib < na + nb) begin
			v = '0;
			if (ib >= nb - 1 && ia < na) v.op = OP_FIRST;
			else if (ia >= na) v.op = OP_SECOND;
			else v.op = logic'($urandom_range(1));
			// occasional kind flip mid-geometry: latest vertex decides
			v.kind = (v.op == OP_FIRST) ? ka : kb;
			if ($urandom_range(29) == 0) v.kind = pick_kind();
			v.x = pick_coord(mode);
			v.y = pick_coord(mode);
			if (v.op == OP_FIRST) ia++; else ib++;
			v.last = (ia + ib == na + nb);
			stim_q = {stim_q, v};
		end
		// now and then close on opcode 0 with an extra A vertex
		if ($urandom_range(14) == 0) begin
			stim_q[$].last = 1'b0;
			v = '0;
			v.op = OP_FIRST; v.kind = ka;
			v.x = pick_coord(mode); v.y = pick_coord(mode); v.last = 1'b1;
			stim_q = {stim_q, v};
		end
	endtask

	// send one transaction; valid stays high across back-to-back sends
	task automatic send(vertex_t v);
		in_valid     <= 1'b1;
		opcode       <= v.op;
		kind         <= v.kind;
		x_coord      <= v.x;
		y_coord      <= v.y;
		last_of_pair <= v.last;
		cur_fixed    <= v.fixed;
		cur_fixed_v  <= '{v.f_hit, v.f_st};
		do @(posedge clk); while (!in_ready);
		sent++;
	endtask

	// drain stim_q in bursts with random gaps
	task automatic play_queue();
		int burst;
		while (stim_q.size() != 0) begin
			burst = $urandom_range(24, 1);
			while (burst > 0 && stim_q.size() != 0) begin
				send(stim_q.pop_front());
				burst--;
			end
			if ($urandom_range(3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(6, 1)) @(posedge clk);
			end
		end
		in_valid <= 1'b0;
	endtask

	initial begin
		vertex_t v;
		int n;
		gcount[0] = 0; gcount[1] = 0;
		gkind[0] = KIND_POINT; gkind[1] = KIND_POINT;
		overflowed = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (int i = 0; i < DIR_N; i++) stim_q = {stim_q, DIR_TAB[i]};
		// store overflow: one vertex more than the store holds
		for (int i = 0; i <= MAX_VERTS; i++) begin
			v = '0;
			v.op = OP_FIRST; v.kind = KIND_RING; v.x = i; v.y = -i;
			stim_q = {stim_q, v};
		end
		v = '0;
		v.op = OP_SECOND; v.kind = KIND_POINT; v.last = 1'b1;
		v.fixed = 1'b1; v.f_hit = 1'b0; v.f_st = ST_OVERFLOW;
		stim_q = {stim_q, v};
		play_queue();

		// sender holds off until every pending verdict has arrived
		while (verdict_q.size() != 0) @(posedge clk);

		// random pairs; one full-size ring against a triangle
		n = 0;
		while (sent < TARGET_ITEMS) begin
			add_pair(n == 40);
			n++;
			play_queue();
		end

		n = 0;
		while (verdict_q.size() != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (100) @(posedge clk);
		if (verdict_q.size() != 0)
			report("results still pending", 0, verdict_q.size());
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// ---------------------------------------------------------------- receiver
	// ready runs and stalls of random length, plus one long hold-off once the
	// bench has a backlog, so the block fills up and stalls its input
	initial begin
		int run, held;
		bit did_hold;
		did_hold = 0;
		@(posedge arst_n);
		forever begin
			if (!did_hold && sent > 320) begin
				did_hold = 1;
				out_ready <= 1'b0;
				held = 0;
				while (held < 600) begin
					@(posedge clk);
					held++;
				end
			end
			run = $urandom_range(30);
			out_ready <= 1'b1;
			repeat (run + 1) @(posedge clk);
			if ($urandom_range(3) != 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(8, 1)) @(posedge clk);
			end
		end
	end

	// hard stop
	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end

endmodule
